>>> sv/i2c_rpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rpt_pkg
// Shared types, constants and helpers for the I2C register pointer tracker.
// ----------------------------------------------------------------------------
package i2c_rpt_pkg;

  localparam int ADDR_BITS = 16;   // register pointer / length store depth bits
  localparam int LEN_BITS  = 8;    // per-register buffer length width
  localparam int IDX_BITS  = 8;    // byte_index field width
  localparam int REG_BITS  = 16;   // register_address field width
  localparam int SEG_BITS  = 16;   // segment_number field width
  localparam int WBS_BITS  = 8;    // write bytes seen counter
  localparam int IDX_MAX   = (1 << IDX_BITS) - 1;

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
  localparam logic [WBS_BITS-1:0] WBS_MAX = '1;

  // config register indexes (word address bits)
  localparam logic [1:0] REG_PTR_BYTES   = 2'd0;
  localparam logic [1:0] REG_AUTO_INC    = 2'd1;
  localparam logic [1:0] REG_DIRECT_READ = 2'd2;
  localparam logic [1:0] REG_DEFAULT_REG = 2'd3;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    BUS_STOP     = 2'd0,
    BUS_FIRST    = 2'd1,
    BUS_REPEATED = 2'd2
  } bus_e;

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_ADDR  = 2'd1,
    KIND_DATA  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_APPEND  = 2'd2,
    OP_RESTART = 2'd3
  } mem_op_e;

  typedef enum logic [1:0] {
    S1_EMPTY  = 2'd0,
    S1_FULL   = 2'd1,
    S1_SECOND = 2'd2
  } s1_state_e;

  typedef struct packed {
    logic [1:0]          addr_bytes;
    logic                auto_inc;
    logic                direct_read;
    logic [REG_BITS-1:0] default_reg;
  } cfg_t;

  // length store operation for one item; dbl adds a clear of read entry 0
  typedef struct packed {
    mem_op_e              op;
    logic                 sel_read;
    logic [ADDR_BITS-1:0] addr;
    logic                 dbl;
  } mem_req_t;

  typedef struct packed {
    kind_e               kind;
    logic [REG_BITS-1:0] register_address;
    logic [IDX_BITS-1:0] byte_index;
    logic                is_read;
    logic                buffer_restarted;
    bus_e                start_kind;
    logic [SEG_BITS-1:0] segment_number;
  } result_t;

  function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] v);
    if (v == LEN_MAX) return v;
    return v + 1'b1;
  endfunction

  function automatic logic [IDX_BITS-1:0] sat_index(input logic [LEN_BITS-1:0] v);
    if (int'(v) > IDX_MAX) return '1;
    return IDX_BITS'(v);
  endfunction

endpackage

>>> sv/i2c_rpt_len_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rpt_len_store
// Read and write length memories with sweep clear and write-first bypass.
// ----------------------------------------------------------------------------
module i2c_rpt_len_store (
  input  logic                              clk,
  input  logic                              rst,
  output logic                              ready,
  input  logic                              rd_en,
  input  logic                              rd_sel,
  input  logic [i2c_rpt_pkg::ADDR_BITS-1:0] rd_addr,
  output logic [i2c_rpt_pkg::LEN_BITS-1:0]  rd_data,
  input  logic                              wr_en,
  input  logic                              wr_sel,
  input  logic [i2c_rpt_pkg::ADDR_BITS-1:0] wr_addr,
  input  logic [i2c_rpt_pkg::LEN_BITS-1:0]  wr_data
);
  import i2c_rpt_pkg::*;

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [LEN_BITS-1:0]  wlen_mem [DEPTH];
  logic [LEN_BITS-1:0]  rlen_mem [DEPTH];

  logic                 clearing;
  logic [ADDR_BITS-1:0] clr_addr;
  logic [ADDR_BITS-1:0] wa;
  logic [LEN_BITS-1:0]  wd;
  logic                 we_w;
  logic                 we_r;
  logic [LEN_BITS-1:0]  rd_w_q;
  logic [LEN_BITS-1:0]  rd_r_q;
  logic                 sel_q;
  logic                 byp_hit;
  logic [LEN_BITS-1:0]  byp_data;

  assign ready = !clearing;
  assign wa    = clearing ? clr_addr : wr_addr;
  assign wd    = clearing ? '0 : wr_data;
  assign we_w  = clearing || (wr_en && !wr_sel);
  assign we_r  = clearing || (wr_en && wr_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) clearing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we_w) wlen_mem[wa] <= wd;
    if (rd_en) rd_w_q <= wlen_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_r) rlen_mem[wa] <= wd;
    if (rd_en) rd_r_q <= rlen_mem[rd_addr];
  end

  // a write at the read edge is not seen by the array read: forward it
  always_ff @(posedge clk) begin
    if (rd_en) begin
      sel_q    <= rd_sel;
      byp_hit  <= wr_en && (wr_sel == rd_sel) && (wr_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp_hit ? byp_data : (sel_q ? rd_r_q : rd_w_q);

  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(wr_en || rd_en))
    else $error("length store accessed during clear sweep");

endmodule

>>> sv/i2c_rpt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rpt_ctrl
// Bus condition, pointer and counters; decodes each item into a store request.
// ----------------------------------------------------------------------------
module i2c_rpt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [1:0]            cmd,
  input  logic                  rd,
  input  logic [7:0]            data,
  input  i2c_rpt_pkg::cfg_t     cfg,
  output i2c_rpt_pkg::mem_req_t req,
  output i2c_rpt_pkg::result_t  res
);
  import i2c_rpt_pkg::*;

  bus_e                 bs, bs_next;
  logic [SEG_BITS-1:0]  seg, seg_next;
  logic [ADDR_BITS-1:0] ptr, ptr_next;
  logic                 dir, dir_next;
  logic [WBS_BITS-1:0]  wbs, wbs_next;
  logic                 rp, rp_next;

  logic [1:0]           nab;
  logic [WBS_BITS-1:0]  nab_w;
  logic                 do_store;
  logic                 st_sel;
  logic [ADDR_BITS-1:0] st_ptr;
  logic [ADDR_BITS-1:0] p0;
  logic                 set_rp;

  assign nab   = (cfg.addr_bytes == 2'd3) ? 2'd2 : cfg.addr_bytes;
  assign nab_w = WBS_BITS'(nab);

  always_comb begin
    bs_next  = bs;
    seg_next = seg;
    ptr_next = ptr;
    dir_next = dir;
    wbs_next = wbs;
    rp_next  = rp;
    do_store = 1'b0;
    st_sel   = 1'b0;
    st_ptr   = ptr;
    set_rp   = 1'b0;
    p0       = (wbs == '0) ? '0 : ptr;
    req      = '{op: OP_NONE, sel_read: 1'b0, addr: '0, dbl: 1'b0};
    res.kind             = KIND_EVENT;
    res.register_address = REG_BITS'(ptr);
    res.byte_index       = '0;
    res.buffer_restarted = 1'b0;

    case (cmd)
      CMD_START: begin
        seg_next = seg + 1'b1;
        bs_next  = (bs == BUS_STOP) ? BUS_FIRST : BUS_REPEATED;
        dir_next = rd;
        wbs_next = '0;
        if (rd && cfg.direct_read && (bs_next == BUS_FIRST)) begin
          ptr_next     = cfg.default_reg[ADDR_BITS-1:0];
          req.op       = OP_CLEAR;
          req.sel_read = 1'b1;
          req.addr     = ptr_next;
        end
        if (nab == 2'd0) begin
          ptr_next = '0;
          // direct read plus registerless: two read entries to clear
          if (req.op == OP_CLEAR) begin
            req.dbl = 1'b1;
          end else begin
            req.op       = OP_CLEAR;
            req.sel_read = rd;
            req.addr     = '0;
          end
        end
        res.register_address = REG_BITS'(ptr_next);
      end
      CMD_DATA: begin
        if (nab == 2'd0) begin
          ptr_next             = '0;
          res.kind             = KIND_DATA;
          res.register_address = '0;
          req.op               = OP_APPEND;
          req.sel_read         = dir;
          req.addr             = '0;
        end else if (dir) begin
          do_store = 1'b1;
          st_sel   = 1'b1;
          st_ptr   = ptr;
        end else begin
          if (wbs < nab_w) begin
            ptr_next             = ADDR_BITS'({p0, data});
            res.kind             = KIND_ADDR;
            res.register_address = REG_BITS'(ptr_next);
            res.byte_index       = IDX_BITS'(wbs);
          end else begin
            do_store = 1'b1;
            st_sel   = 1'b0;
            st_ptr   = p0;
          end
          wbs_next = (wbs == WBS_MAX) ? wbs : wbs + 1'b1;
          set_rp   = (wbs_next == nab_w);
        end
      end
      CMD_STOP: begin
        bs_next = BUS_STOP;
      end
      default: begin
      end
    endcase

    if (do_store) begin
      res.kind             = KIND_DATA;
      res.register_address = REG_BITS'(st_ptr);
      res.buffer_restarted = rp;
      req.op               = rp ? OP_RESTART : OP_APPEND;
      req.sel_read         = st_sel;
      req.addr             = st_ptr;
      if (rp) rp_next = 1'b0;
      if (cfg.auto_inc) begin
        ptr_next = st_ptr + 1'b1;
        rp_next  = 1'b1;
      end
    end
    if (set_rp) rp_next = 1'b1;

    res.is_read        = dir_next;
    res.start_kind     = bs_next;
    res.segment_number = seg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bs  <= BUS_STOP;
      seg <= '0;
      ptr <= '0;
      dir <= 1'b0;
      wbs <= '0;
      rp  <= 1'b0;
    end else if (accept) begin
      bs  <= bs_next;
      seg <= seg_next;
      ptr <= ptr_next;
      dir <= dir_next;
      wbs <= wbs_next;
      rp  <= rp_next;
    end
  end

endmodule

>>> sv/i2c_rpt_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_rpt_update
// Second stage: length read-modify-write, byte index and output register.
// ----------------------------------------------------------------------------
module i2c_rpt_update (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  output logic                              slot_free,
  input  i2c_rpt_pkg::mem_req_t             req,
  input  i2c_rpt_pkg::result_t              res_in,
  input  logic [i2c_rpt_pkg::LEN_BITS-1:0]  rd_data,
  output logic                              wr_en,
  output logic                              wr_sel,
  output logic [i2c_rpt_pkg::ADDR_BITS-1:0] wr_addr,
  output logic [i2c_rpt_pkg::LEN_BITS-1:0]  wr_data,
  output logic                              m_valid,
  input  logic                              m_ready,
  output i2c_rpt_pkg::result_t              m_res
);
  import i2c_rpt_pkg::*;

  s1_state_e st, st_next;
  mem_req_t  req_q;
  result_t   res_q;
  result_t   res_out;
  logic      out_free;
  logic      fin;
  logic [LEN_BITS-1:0] upd_len;

  assign out_free = !m_valid || m_ready;

  always_comb begin
    case (st)
      S1_EMPTY:  st_next = load ? S1_FULL : S1_EMPTY;
      S1_FULL: begin
        if (req_q.dbl)     st_next = S1_SECOND;
        else if (out_free) st_next = load ? S1_FULL : S1_EMPTY;
        else               st_next = S1_FULL;
      end
      S1_SECOND: begin
        if (out_free) st_next = load ? S1_FULL : S1_EMPTY;
        else          st_next = S1_SECOND;
      end
      default:   st_next = S1_EMPTY;
    endcase
  end

  always_comb begin
    res_out = res_q;
    upd_len = '0;
    case (req_q.op)
      OP_APPEND: begin
        res_out.byte_index = sat_index(rd_data);
        upd_len            = len_inc(rd_data);
      end
      OP_RESTART: begin
        res_out.byte_index = '0;
        upd_len            = len_inc('0);
      end
      default: upd_len = '0;
    endcase

    fin     = 1'b0;
    wr_en   = 1'b0;
    wr_sel  = req_q.sel_read;
    wr_addr = req_q.addr;
    wr_data = upd_len;
    case (st)
      S1_FULL: begin
        if (req_q.dbl) begin
          wr_en   = 1'b1;
          wr_data = '0;
        end else if (out_free) begin
          fin   = 1'b1;
          wr_en = (req_q.op != OP_NONE);
        end
      end
      S1_SECOND: begin
        if (out_free) begin
          fin     = 1'b1;
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = '0;
        end
      end
      default: begin
      end
    endcase
    slot_free = (st == S1_EMPTY) || fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= S1_EMPTY;
      m_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (fin)          m_valid <= 1'b1;
      else if (m_ready) m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_q <= req;
      res_q <= res_in;
    end
    if (fin) m_res <= res_out;
  end

  a_second_once: assert property (@(posedge clk) disable iff (rst)
    (st == S1_SECOND && out_free) |=> st != S1_SECOND)
    else $error("double clear held the slot for more than two writes");

  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (st == S1_EMPTY || fin))
    else $error("item loaded over an unfinished one");

  a_restart_index: assert property (@(posedge clk) disable iff (rst)
    (m_valid && m_res.buffer_restarted) |-> m_res.byte_index == '0)
    else $error("restarted buffer reported a nonzero index");

endmodule

>>> sv/i2c_register_pointer_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_pointer_tracker
// Follows an I2C device register pointer per bus event, keeps per-register
// read/write buffer lengths and reports one beat per event.
// ----------------------------------------------------------------------------
// Pipeline: an item is held in the stage 1 register from its accept edge, and
//   its result beat goes valid when the output register m_res loads. A start
//   that loads the default register while registerless makes two length clears.
// Throughput: one item per cycle while the result stream keeps up; that
//   double-clear start holds the input until its second clear is written.
// Reset: control state clears at once, then a sweep over all 65536 addresses
//   zeroes the length memories with s_axis_tready low; APB writes are taken throughout.
// ----------------------------------------------------------------------------
module i2c_register_pointer_tracker (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [2:0]  s_axis_tuser,   // [1:0] command, [2] read_dir
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] register_address, [23:16] byte_index,
                                      // [24] is_read, [25] buffer_restarted,
                                      // [27:26] start_kind, [43:28] segment_number,
                                      // [47:44] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] byte_kind
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2c_rpt_pkg::*;

  cfg_t     cfg;
  mem_req_t req;
  result_t  res_c;
  result_t  m_res;

  logic                 accept;
  logic                 store_ready;
  logic                 slot_free;
  logic                 rd_en;
  logic [LEN_BITS-1:0]  rd_data;
  logic                 wr_en;
  logic                 wr_sel;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [LEN_BITS-1:0]  wr_data;
  logic                 cfg_we;

  // ---------------- APB register file ----------------
  // Registers live at byte address 4*i; paddr[1:0] is ignored.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.addr_bytes  <= 2'd1;
      cfg.auto_inc    <= 1'b1;
      cfg.direct_read <= 1'b0;
      cfg.default_reg <= '0;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_PTR_BYTES:   cfg.addr_bytes  <= pwdata[1:0];
        REG_AUTO_INC:    cfg.auto_inc    <= pwdata[0];
        REG_DIRECT_READ: cfg.direct_read <= pwdata[0];
        REG_DEFAULT_REG: cfg.default_reg <= pwdata[REG_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PTR_BYTES:   prdata = 32'(cfg.addr_bytes);
      REG_AUTO_INC:    prdata = 32'(cfg.auto_inc);
      REG_DIRECT_READ: prdata = 32'(cfg.direct_read);
      REG_DEFAULT_REG: prdata = 32'(cfg.default_reg);
      default:         prdata = '0;
    endcase
  end

  // ---------------- stage 0: accept and decode ----------------
  // The control state updates at the accept edge; only the byte index
  // depends on the length memory, so the result waits in stage 1 for the length.
  assign s_axis_tready = store_ready && slot_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  i2c_rpt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (s_axis_tuser[1:0]),
    .rd     (s_axis_tuser[2]),
    .data   (s_axis_tdata),
    .cfg    (cfg),
    .req    (req),
    .res    (res_c)
  );

  // The length read is launched at the accept edge; data comes back for
  // stage 1 on the next cycle, with bypass from a write at that same edge.
  assign rd_en = accept && (req.op == OP_APPEND);

  i2c_rpt_len_store u_store (
    .clk     (clk),
    .rst     (rst),
    .ready   (store_ready),
    .rd_en   (rd_en),
    .rd_sel  (req.sel_read),
    .rd_addr (req.addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_sel  (wr_sel),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // ---------------- stage 1: length update and result beat ----------------
  i2c_rpt_update u_update (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .slot_free (slot_free),
    .req       (req),
    .res_in    (res_c),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_sel    (wr_sel),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_res     (m_res)
  );

  assign m_axis_tuser = m_res.kind;
  assign m_axis_tdata = {4'd0,
                         m_res.segment_number,
                         m_res.start_kind,
                         m_res.buffer_restarted,
                         m_res.is_read,
                         m_res.byte_index,
                         m_res.register_address};

endmodule
